/* hw/rtl/deq_pkg.sv */
// Package for the double-ended queue engine: sizes, operation and status codes,
// the cell command type and the request and response payload structs.
// Used by deq_cell and double_ended_queue_engine; depends on nothing.
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT,
      CELL_LOAD
   } cell_cmd_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [1:0]  status;
      logic [4:0]  entry_count;
   } rsp_type;

endpackage

/* hw/rtl/double_ended_queue_engine.sv */
// Double-ended queue engine: a row of storage cells with the front entry in
// cell 0, and a response register. Depends on deq_pkg and deq_cell.
// The response is registered and appears in the cycle after the request transfer.
// Throughput: one request per cycle while the response side does not stall.
// Reset clears the entry count and the response valid; cell contents stay
// undefined until written.
module double_ended_queue_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_payload
);

   logic [deq_pkg::CNT_W-1:0]      count_ff;
   logic [deq_pkg::CNT_W-1:0]      count_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   deq_pkg::rsp_type               rsp_ff;
   deq_pkg::rsp_type               rsp_in;
   logic                           accept;
   logic                           full;
   logic                           empty;
   logic [deq_pkg::WORD_WIDTH-1:0] push_word;
   deq_pkg::cell_cmd_type          cmd      [deq_pkg::DEPTH];
   logic [deq_pkg::WORD_WIDTH-1:0] cell_word[deq_pkg::DEPTH];
   logic [deq_pkg::WORD_WIDTH-1:0] tail_in  [deq_pkg::DEPTH];
   logic [deq_pkg::WORD_WIDTH-1:0] tail_out [deq_pkg::DEPTH];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign full      = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign push_word = req_payload.push_value[deq_pkg::WORD_WIDTH-1:0];

   for (genvar g = 0; g < deq_pkg::DEPTH; g++) begin : g_cell
      always_comb begin
         cmd[g] = deq_pkg::CELL_HOLD;
         if (accept) begin
            unique case (req_payload.opcode)
               deq_pkg::OP_PUSH_FRONT: begin
                  if (!full) cmd[g] = deq_pkg::CELL_TAKE_LEFT;
               end
               deq_pkg::OP_PUSH_BACK: begin
                  if (!full && count_ff == deq_pkg::CNT_W'(g)) cmd[g] = deq_pkg::CELL_LOAD;
               end
               deq_pkg::OP_POP_FRONT: begin
                  if (!empty) cmd[g] = deq_pkg::CELL_TAKE_RIGHT;
               end
               default: cmd[g] = deq_pkg::CELL_HOLD;
            endcase
         end
      end

      if (g == deq_pkg::DEPTH - 1) begin : g_last
         assign tail_in[g] = '0;
      end else begin : g_inner
         assign tail_in[g] = tail_out[g+1];
      end

      deq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd[g]),
         .left_word  ((g == 0) ? push_word : cell_word[(g == 0) ? 0 : g - 1]),
         .right_word ((g == deq_pkg::DEPTH - 1) ? '0 :
                      cell_word[(g == deq_pkg::DEPTH - 1) ? g : g + 1]),
         .push_word  (push_word),
         .tail_sel   (deq_pkg::CNT_W'(g + 1) == count_ff),
         .tail_in    (tail_in[g]),
         .word       (cell_word[g]),
         .tail_out   (tail_out[g])
      );
   end

   always_comb begin
      count_in           = count_ff;
      rsp_in.read_value  = '0;
      rsp_in.status      = deq_pkg::STATUS_OK;
      unique case (req_payload.opcode)
         deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
            if (full) rsp_in.status = deq_pkg::STATUS_FULL;
            else count_in = count_ff + 1'b1;
         end
         deq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               rsp_in.status = deq_pkg::STATUS_EMPTY;
            end else begin
               rsp_in.read_value = 32'(cell_word[0]);
               count_in          = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (empty) begin
               rsp_in.status = deq_pkg::STATUS_EMPTY;
            end else begin
               rsp_in.read_value = 32'(tail_out[0]);
               count_in          = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_PEEK_FRONT: begin
            if (empty) rsp_in.status = deq_pkg::STATUS_EMPTY;
            else rsp_in.read_value = 32'(cell_word[0]);
         end
         default: count_in = count_ff;
      endcase
      rsp_in.entry_count = 5'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && !full &&
      (req_payload.opcode == deq_pkg::OP_PUSH_FRONT ||
       req_payload.opcode == deq_pkg::OP_PUSH_BACK)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("A successful push did not raise the entry count.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == deq_pkg::STATUS_FULL
      |-> rsp_ff.entry_count == 5'(deq_pkg::DEPTH) && rsp_ff.read_value == '0)
      else $error("Full status reported with a queue that was not full.");

endmodule

/* hw/rtl/deq_cell.sv */
// One storage cell of the queue row: holds a word, takes it from either
// neighbour or from the push data, and ORs its word into the tail read chain when it is the tail.
// Depends on deq_pkg.
module deq_cell (
   input  logic                             clock,
   input  deq_pkg::cell_cmd_type            cmd,
   input  logic [deq_pkg::WORD_WIDTH-1:0]   left_word,
   input  logic [deq_pkg::WORD_WIDTH-1:0]   right_word,
   input  logic [deq_pkg::WORD_WIDTH-1:0]   push_word,
   input  logic                             tail_sel,
   input  logic [deq_pkg::WORD_WIDTH-1:0]   tail_in,
   output logic [deq_pkg::WORD_WIDTH-1:0]   word,
   output logic [deq_pkg::WORD_WIDTH-1:0]   tail_out
);

   logic [deq_pkg::WORD_WIDTH-1:0] word_ff;
   logic [deq_pkg::WORD_WIDTH-1:0] word_in;

   always_comb begin
      unique case (cmd)
         deq_pkg::CELL_TAKE_LEFT:  word_in = left_word;
         deq_pkg::CELL_TAKE_RIGHT: word_in = right_word;
         deq_pkg::CELL_LOAD:       word_in = push_word;
         default:                  word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word     = word_ff;
   assign tail_out = tail_in | (tail_sel ? word_ff : '0);

endmodule
